### rtl/core/hcc_pkg.sv
`default_nettype none
package hcc_pkg;

	localparam int ADDR_W = 16;

	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_MWR  = 3'd1;
	localparam logic [2:0] CMD_MRD  = 3'd2;
	localparam logic [2:0] CMD_IOW  = 3'd3;
	localparam logic [2:0] CMD_IOR  = 3'd4;
	localparam logic [2:0] CMD_RST  = 3'd5;

	// where stage 2 puts the byte from the data read port
	localparam logic [2:0] LD_NONE   = 3'd0;
	localparam logic [2:0] LD_RDATA  = 3'd1;
	localparam logic [2:0] LD_LOGIC  = 3'd2;
	localparam logic [2:0] LD_POP_LO = 3'd3;
	localparam logic [2:0] LD_POP_HI = 3'd4;

	localparam logic [1:0] LOG_AND = 2'd0;
	localparam logic [1:0] LOG_XOR = 2'd1;

	localparam logic [3:0] FZ = 4'b1000;
	localparam logic [3:0] FN = 4'b0100;
	localparam logic [3:0] FH = 4'b0010;
	localparam logic [3:0] FC = 4'b0001;

	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_STOP = 8'h10;
	localparam logic [7:0] OP_CPL  = 8'h2F;
	localparam logic [7:0] OP_SCF  = 8'h37;
	localparam logic [7:0] OP_CCF  = 8'h3F;
	localparam logic [7:0] OP_HALT = 8'h76;
	localparam logic [7:0] OP_DI   = 8'hF3;
	localparam logic [7:0] OP_EI   = 8'hFB;
	localparam logic [7:0] OP_ANDI = 8'hE6;
	localparam logic [7:0] OP_XORI = 8'hEE;
	localparam logic [7:0] OP_ORI  = 8'hF6;
	localparam logic [7:0] OP_POPB = 8'hC1;
	localparam logic [7:0] OP_POPD = 8'hD1;
	localparam logic [7:0] OP_POPH = 8'hE1;
	localparam logic [7:0] OP_POPA = 8'hF1;
	localparam logic [7:0] OP_PSHB = 8'hC5;
	localparam logic [7:0] OP_PSHD = 8'hD5;
	localparam logic [7:0] OP_PSHH = 8'hE5;
	localparam logic [7:0] OP_PSHA = 8'hF5;
	localparam logic [7:0] OP_PFX  = 8'hCB;
	localparam logic [7:0] OP_LOG_LO = 8'hA0;
	localparam logic [7:0] OP_LOG_HI = 8'hB7;
	localparam logic [2:0] SRC_HL  = 3'd6;
	localparam logic [2:0] SRC_A   = 3'd7;
	localparam logic [1:0] PAIR_AF = 2'd3;

	localparam logic [7:0]  IF_FILL   = 8'hE0;
	localparam logic [15:0] IO_IF     = 16'hFF0F;
	localparam logic [15:0] IO_IE     = 16'hFFFF;
	localparam logic [7:0]  IO_NONE   = 8'hFF;
	localparam logic [15:0] VEC_BASE  = 16'h0040;
	localparam logic [15:0] VEC_STEP  = 16'h0008;
	localparam int          SRC_BTN   = 4;
	localparam logic [2:0]  IRQ_LAST  = 3'd4;

	localparam logic [7:0]  BOOT_A  = 8'h01;
	localparam logic [7:0]  BOOT_B  = 8'h00;
	localparam logic [7:0]  BOOT_C  = 8'h13;
	localparam logic [7:0]  BOOT_D  = 8'h00;
	localparam logic [7:0]  BOOT_E  = 8'hD8;
	localparam logic [7:0]  BOOT_H  = 8'h01;
	localparam logic [7:0]  BOOT_L  = 8'h4D;
	localparam logic [15:0] BOOT_PC = 16'h0100;
	localparam logic [15:0] BOOT_SP = 16'hFFFE;
	localparam logic [7:0]  BOOT_IF = 8'hE1;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] pc;
		logic [7:0]  a;
		logic [3:0]  flags;
		logic [15:0] sp;
		logic        halted;
		logic        stopped;
		logic        ime;
		logic        unsup;
	} res_t;

	typedef struct packed {
		logic        en;
		logic [15:0] ra;
		logic [15:0] rb;
		logic        we;
		logic [15:0] wa;
		logic [7:0]  wd;
	} mem_req_t;

endpackage
`default_nettype wire

### rtl/core/hcc_mem.sv
`default_nettype none
module hcc_mem
	import hcc_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output logic [7:0]    qa,
	output logic [7:0]    qb
);

	logic [7:0] mem [0:(1 << ADDR_W) - 1];

	// a read of the byte written at the same edge returns the new byte
	always_ff @(posedge clk) begin
		if (req.en) begin
			qa <= (req.we && req.wa == req.ra) ? req.wd : mem[req.ra];
			qb <= (req.we && req.wa == req.rb) ? req.wd : mem[req.rb];
		end
		if (req.we) begin
			mem[req.wa] <= req.wd;
		end
	end

endmodule
`default_nettype wire

### rtl/core/hcc_ctl.sv
`default_nettype none
module hcc_ctl
	import hcc_pkg::*;
#(
	parameter int IRQ_SOURCES = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic        advance,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	input  wire logic        boot_rom,
	input  wire logic [7:0]  checksum,
	output logic             valid_s1,
	output res_t             res
);

	localparam logic [7:0] IRQ_MASK = 8'((1 << IRQ_SOURCES) - 1);

	logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q, opc_q, if_q, ie_q;
	logic [3:0]  f_q;
	logic [15:0] pc_q, sp_q, vec_q;
	logic        pfx_q, ime_q, halt_q, hbug_q, stop_q;
	logic [1:0]  step_q, eid_q, div_q;
	logic [2:0]  istep_q;

	logic [2:0]  ld_s1;
	logic        opc_s1, unsup_s1;
	logic [1:0]  lkind_s1, pair_s1;
	logic [7:0]  io_s1;

	logic [7:0]  rda, rdb;
	mem_req_t    req;

	// stage 2: values after the in-flight read lands
	logic [7:0]  a2, b2, c2, d2, e2, h2, l2, opc2;
	logic [3:0]  f2;
	logic        pfx2;

	logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l, n_if, n_ie, n_io, pend, opnd, pv;
	logic [3:0]  n_f;
	logic [15:0] n_pc, n_sp, n_vec;
	logic        n_ime, n_halt, n_hbug, n_stop, n_opc, n_unsup, more, found;
	logic [1:0]  n_step, n_eid, n_div, n_lkind, n_pair;
	logic [2:0]  n_istep, n_ld;

	hcc_mem u_mem (
		.clk (clk),
		.req (req),
		.qa  (rda),
		.qb  (rdb)
	);

	always_comb begin
		a2 = a_q; f2 = f_q; b2 = b_q; c2 = c_q; d2 = d_q; e2 = e_q; h2 = h_q; l2 = l_q;
		opc2 = opc_q; pfx2 = pfx_q;
		if (valid_s1 && opc_s1) begin
			opc2 = rdb;
			pfx2 = (rdb == OP_PFX);
		end
		if (valid_s1) begin
			unique case (ld_s1)
				LD_LOGIC: begin
					if (lkind_s1 == LOG_AND)
						a2 = a_q & rda;
					else if (lkind_s1 == LOG_XOR)
						a2 = a_q ^ rda;
					else
						a2 = a_q | rda;
					f2 = ((a2 == 8'd0) ? FZ : 4'd0) | ((lkind_s1 == LOG_AND) ? FH : 4'd0);
				end
				LD_POP_LO: begin
					unique case (pair_s1)
						2'd0: c2 = rda;
						2'd1: e2 = rda;
						2'd2: l2 = rda;
						default: f2 = rda[7:4];
					endcase
				end
				LD_POP_HI: begin
					unique case (pair_s1)
						2'd0: b2 = rda;
						2'd1: d2 = rda;
						2'd2: h2 = rda;
						default: a2 = rda;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.read_data = (ld_s1 == LD_RDATA) ? rda : io_s1;
		res.pc        = pc_q;
		res.a         = a2;
		res.flags     = f2;
		res.sp        = sp_q;
		res.halted    = halt_q;
		res.stopped   = stop_q;
		res.ime       = ime_q;
		res.unsup     = unsup_s1;
	end

	// stage 1: everything that needs no read data
	always_comb begin
		n_a = a2; n_f = f2; n_b = b2; n_c = c2; n_d = d2; n_e = e2; n_h = h2; n_l = l2;
		n_if = if_q; n_ie = ie_q; n_pc = pc_q; n_sp = sp_q; n_vec = vec_q;
		n_ime = ime_q; n_halt = halt_q; n_hbug = hbug_q; n_stop = stop_q;
		n_step = step_q; n_eid = eid_q; n_div = div_q; n_istep = istep_q;
		n_ld = LD_NONE; n_opc = 1'b0; n_unsup = 1'b0; n_io = 8'd0;
		n_lkind = opc2[4:3]; n_pair = opc2[5:4];
		more = 1'b0; found = 1'b0; opnd = 8'd0; pv = 8'd0;
		pend = if_q & ie_q & IRQ_MASK;
		req.en = accept; req.ra = address; req.rb = pc_q;
		req.we = 1'b0; req.wa = sp_q; req.wd = data;

		unique case (command)
			CMD_TICK: begin
				if (div_q != 2'd0) begin
					n_div = div_q - 2'd1;
				end else begin
					n_div = 2'd3;
					if (halt_q && pend != 8'd0)
						n_halt = 1'b0;
					if (step_q == 2'd0 && ((ime_q && pend != 8'd0) || istep_q != 3'd0)) begin
						unique case (istep_q)
							3'd0: n_istep = 3'd1;
							3'd1: begin
								for (int n = 0; n < IRQ_SOURCES; n++) begin
									if (!found && pend[n]) begin
										found = 1'b1;
										if (n == SRC_BTN)
											n_stop = 1'b0;
										n_vec = VEC_BASE + 16'(VEC_STEP * 16'(n));
										n_if[n] = 1'b0;
										n_ime = 1'b0;
									end
								end
								n_istep = 3'd2;
							end
							3'd2: begin
								n_sp = sp_q - 16'd1;
								req.we = accept; req.wa = n_sp; req.wd = pc_q[15:8];
								n_istep = 3'd3;
							end
							3'd3: begin
								n_sp = sp_q - 16'd1;
								req.we = accept; req.wa = n_sp; req.wd = pc_q[7:0];
								n_istep = IRQ_LAST;
							end
							default: begin
								req.rb = vec_q;
								n_pc = vec_q + 16'd1;
								n_opc = 1'b1;
								n_istep = 3'd0;
							end
						endcase
					end else if (step_q != 2'd0 || (!n_halt && !stop_q)) begin
						if (pfx2) begin
							// the byte after the prefix is skipped without being read
							n_pc = pc_q + 16'd1;
							n_unsup = 1'b1;
						end else if (opc2 >= OP_LOG_LO && opc2 <= OP_LOG_HI) begin
							if (opc2[2:0] != SRC_HL) begin
								unique case (opc2[2:0])
									3'd0: opnd = b2;
									3'd1: opnd = c2;
									3'd2: opnd = d2;
									3'd3: opnd = e2;
									3'd4: opnd = h2;
									3'd5: opnd = l2;
									SRC_A: opnd = a2;
									default: opnd = b2;
								endcase
								if (opc2[4:3] == LOG_AND)
									n_a = a2 & opnd;
								else if (opc2[4:3] == LOG_XOR)
									n_a = a2 ^ opnd;
								else
									n_a = a2 | opnd;
								n_f = ((n_a == 8'd0) ? FZ : 4'd0) |
									((opc2[4:3] == LOG_AND) ? FH : 4'd0);
							end else if (step_q == 2'd0) begin
								more = 1'b1;
							end else begin
								req.ra = {h2, l2};
								n_ld = LD_LOGIC;
							end
						end else begin
							unique case (opc2)
								OP_NOP: ;
								OP_STOP: begin
									n_pc = pc_q + 16'd1;
									n_stop = 1'b1;
								end
								OP_CPL: begin
									n_a = ~a2;
									n_f = f2 | FN | FH;
								end
								OP_SCF: n_f = (f2 & FZ) | FC;
								OP_CCF: n_f = (f2 & FZ) | ((f2 & FC) ^ FC);
								OP_HALT: begin
									n_hbug = !ime_q && pend != 8'd0;
									n_halt = 1'b1;
								end
								OP_DI: begin
									n_ime = 1'b0;
									n_eid = 2'd0;
								end
								OP_EI: n_eid = 2'd2;
								OP_ANDI, OP_XORI, OP_ORI: begin
									if (step_q == 2'd0) begin
										more = 1'b1;
									end else begin
										req.ra = pc_q;
										n_pc = pc_q + 16'd1;
										n_ld = LD_LOGIC;
									end
								end
								OP_POPB, OP_POPD, OP_POPH, OP_POPA: begin
									if (step_q == 2'd0) begin
										more = 1'b1;
									end else if (step_q == 2'd1) begin
										req.ra = sp_q;
										n_sp = sp_q + 16'd1;
										n_ld = LD_POP_LO;
										more = 1'b1;
									end else if (step_q == 2'd2) begin
										req.ra = sp_q;
										n_sp = sp_q + 16'd1;
										n_ld = LD_POP_HI;
									end
								end
								OP_PSHB, OP_PSHD, OP_PSHH, OP_PSHA: begin
									if (step_q < 2'd2) begin
										more = 1'b1;
									end else begin
										if (step_q == 2'd2) begin
											unique case (opc2[5:4])
												2'd0: pv = b2;
												2'd1: pv = d2;
												2'd2: pv = h2;
												default: pv = a2;
											endcase
											more = 1'b1;
										end else begin
											unique case (opc2[5:4])
												2'd0: pv = c2;
												2'd1: pv = e2;
												2'd2: pv = l2;
												default: pv = {f2, 4'd0};
											endcase
										end
										n_sp = sp_q - 16'd1;
										req.we = accept; req.wa = n_sp; req.wd = pv;
									end
								end
								default: n_unsup = 1'b1;
							endcase
						end

						if (more) begin
							n_step = step_q + 2'd1;
						end else begin
							n_step = 2'd0;
							req.rb = n_pc;
							n_pc = n_pc + 16'd1;
							n_opc = 1'b1;
							if (n_hbug) begin
								n_hbug = 1'b0;
								n_pc = n_pc - 16'd1;
							end
							if (n_eid != 2'd0) begin
								n_eid = n_eid - 2'd1;
								if (n_eid == 2'd0)
									n_ime = 1'b1;
							end
						end
					end
				end
			end
			CMD_MWR: begin
				req.we = accept; req.wa = address; req.wd = data;
			end
			CMD_MRD: n_ld = LD_RDATA;
			CMD_IOW: begin
				if (address == IO_IF)
					n_if = data | IF_FILL;
				else if (address == IO_IE)
					n_ie = data;
			end
			CMD_IOR: begin
				if (address == IO_IF)
					n_io = if_q;
				else if (address == IO_IE)
					n_io = ie_q;
				else
					n_io = IO_NONE;
			end
			CMD_RST: begin
				if (!boot_rom) begin
					n_a = BOOT_A;
					n_f = FZ | ((checksum != 8'd0) ? (FH | FC) : 4'd0);
					n_b = BOOT_B; n_c = BOOT_C; n_d = BOOT_D;
					n_e = BOOT_E; n_h = BOOT_H; n_l = BOOT_L;
					n_pc = BOOT_PC;
					n_sp = BOOT_SP;
					n_if = BOOT_IF;
				end
				n_div = 2'd3;
				req.rb = n_pc;
				n_pc = n_pc + 16'd1;
				n_opc = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; f_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			h_q <= '0; l_q <= '0; opc_q <= '0; pfx_q <= 1'b0;
			pc_q <= '0; sp_q <= '0; vec_q <= '0; if_q <= '0; ie_q <= '0;
			ime_q <= 1'b0; halt_q <= 1'b0; hbug_q <= 1'b0; stop_q <= 1'b0;
			step_q <= '0; eid_q <= '0; istep_q <= '0; div_q <= 2'd3;
			valid_s1 <= 1'b0; ld_s1 <= LD_NONE; opc_s1 <= 1'b0; unsup_s1 <= 1'b0;
			lkind_s1 <= '0; pair_s1 <= '0; io_s1 <= '0;
		end else if (accept) begin
			a_q <= n_a; f_q <= n_f; b_q <= n_b; c_q <= n_c; d_q <= n_d; e_q <= n_e;
			h_q <= n_h; l_q <= n_l; opc_q <= opc2; pfx_q <= pfx2;
			pc_q <= n_pc; sp_q <= n_sp; vec_q <= n_vec; if_q <= n_if; ie_q <= n_ie;
			ime_q <= n_ime; halt_q <= n_halt; hbug_q <= n_hbug; stop_q <= n_stop;
			step_q <= n_step; eid_q <= n_eid; istep_q <= n_istep; div_q <= n_div;
			valid_s1 <= 1'b1; ld_s1 <= n_ld; opc_s1 <= n_opc; unsup_s1 <= n_unsup;
			lkind_s1 <= n_lkind; pair_s1 <= n_pair; io_s1 <= n_io;
		end else if (advance) begin
			a_q <= a2; f_q <= f2; b_q <= b2; c_q <= c2; d_q <= d2; e_q <= e2;
			h_q <= h2; l_q <= l2; opc_q <= opc2; pfx_q <= pfx2;
			valid_s1 <= 1'b0; ld_s1 <= LD_NONE; opc_s1 <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_rst_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_RST |=> div_q == 2'd3)
		else $error("divider not reloaded by restart");
	a_istep_rng: assert property (@(posedge clk) disable iff (!arst_n)
		istep_q <= IRQ_LAST)
		else $error("dispatch step out of range");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 2'd0 |-> istep_q == 3'd0)
		else $error("instruction and dispatch overlap");
	a_ld_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> ld_s1 == LD_NONE && !opc_s1)
		else $error("load pending without item");
`endif

endmodule
`default_nettype wire

### rtl/core/handheld_cpu_core_with_interrupts.sv
// Handheld 8-bit CPU subset with its interrupt controller and a 64K byte store.
// One command beat is taken per clock while cmd_stall is low; each is answered
// by one result beat (the store's registered read and the stage register load
// at the accepting edge, the result register when the stage advances), so
// sustained rate is one beat per clock while res_stall is low. Every fourth
// tick runs a machine cycle. The store has no reset: reading a byte never
// written returns whatever the RAM holds. Configuration is taken at any time
// (ready is always high) but must only be written while the core is idle.
`default_nettype none
module handheld_cpu_core_with_interrupts
	import hcc_pkg::*;
#(
	parameter int IRQ_SOURCES = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic [2:0]  command,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       read_data,
	output logic [15:0]      program_counter,
	output logic [7:0]       accumulator,
	output logic [3:0]       flag_bits,
	output logic [15:0]      stack_pointer,
	output logic             halted,
	output logic             stopped,
	output logic             master_enable,
	output logic             unsupported_opcode,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic  boot_q;
	logic  [7:0] csum_q;
	logic  valid_s1, advance, accept;
	res_t  res, res_q;

	assign advance   = valid_s1 && (!res_valid || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	hcc_ctl #(.IRQ_SOURCES(IRQ_SOURCES)) u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.advance  (advance),
		.command  (command),
		.address  (address),
		.data     (data),
		.boot_rom (boot_q),
		.checksum (csum_q),
		.valid_s1 (valid_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= 1'b0;
			csum_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index)
				csum_q <= cfg_data;
			else
				boot_q <= cfg_data[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (advance)
			res_valid <= 1'b1;
		else if (!res_stall)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign read_data          = res_q.read_data;
	assign program_counter    = res_q.pc;
	assign accumulator        = res_q.a;
	assign flag_bits          = res_q.flags;
	assign stack_pointer      = res_q.sp;
	assign halted             = res_q.halted;
	assign stopped            = res_q.stopped;
	assign master_enable      = res_q.ime;
	assign unsupported_opcode = res_q.unsup;

endmodule
`default_nettype wire
